// ===== hw/rtl/keyed_reader_writer_lock_table_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the keyed reader/writer lock table
// Clocked assertion helpers, with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef KEYED_READER_WRITER_LOCK_TABLE_ASSERT_SVH
`define KEYED_READER_WRITER_LOCK_TABLE_ASSERT_SVH

// Property checked on every rising edge outside reset.
`define KRWLT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define KRWLT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/krwlt_pkg.sv =====
// ----------------------------------------------------------------------------
// krwlt_pkg
// Sizes, codes and shared types of the keyed reader/writer lock table.
// ----------------------------------------------------------------------------
`default_nettype none

package krwlt_pkg;

  // Table geometry.
  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 64;
  localparam int ID_BITS    = 16;
  localparam int COUNT_BITS = 8;
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int ENTRY_BITS = KEY_BITS + 2 * COUNT_BITS + ID_BITS;

  // Fixed port widths.
  localparam int OP_W     = 2;
  localparam int LKEY_W   = 64;
  localparam int RID_W    = 16;
  localparam int HANDLE_W = 4;
  localparam int STATUS_W = 3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Request opcodes.
  typedef enum logic [OP_W-1:0] {
    OP_SHARED  = 2'd0,
    OP_EXCL    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_QUERY   = 2'd3
  } opcode_t;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 3'd0,
    ST_BUSY   = 3'd1,
    ST_FULL   = 3'd2,
    ST_BADREL = 3'd3,
    ST_LIMIT  = 3'd4
  } status_t;

  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // One stored table entry.
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    count_t              rd;
    count_t              wr;
    logic [ID_BITS-1:0]  owner;
  } entry_t;

  // Outcome of the search or of the handle fetch.
  typedef struct packed {
    logic found;
    idx_t hit_idx;
    logic free_found;
    idx_t free_idx;
    logic handle_ok;
  } lookup_t;

  // Update and response worked out for one request.
  typedef struct packed {
    status_t                status;
    logic                   we;
    idx_t                   widx;
    entry_t                 wdata;
    logic                   valid_val;
    logic [HANDLE_W-1:0]    grant;
    logic                   held;
  } decision_t;

endpackage

`default_nettype wire

// ===== hw/rtl/keyed_reader_writer_lock_table.sv =====
// ----------------------------------------------------------------------------
// keyed_reader_writer_lock_table
// Table of keyed shared/exclusive locks held in one synchronous RAM.
// ----------------------------------------------------------------------------
//
//   channel | handshake             | words
//   --------+-----------------------+---------------------------------------
//   request | req_valid / req_stall | opcode, lock_key, requester_id, handle
//   response| rsp_valid / rsp_stall | status, grant_handle, held_flag
//
// Lock and query words raise their response once the key search has read
// every entry when no entry hits, sooner on an early match; the key search
// reads one entry per cycle from the single RAM read port. A release reads
// its entry by handle and skips the search. The next word can be taken in
// the cycle in which the response is raised. Entry valid bits live in
// flip-flops and clear at reset. A finished response waits in an output
// register while the next request is accepted; that request stalls only at
// its write-back if the response is still held.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_reader_writer_lock_table (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_stall,
  input  wire logic [krwlt_pkg::OP_W-1:0]     opcode,
  input  wire logic [krwlt_pkg::LKEY_W-1:0]   lock_key,
  input  wire logic [krwlt_pkg::RID_W-1:0]    requester_id,
  input  wire logic [krwlt_pkg::HANDLE_W-1:0] release_handle,
  output logic                                rsp_valid,
  input  wire logic                           rsp_stall,
  output logic [krwlt_pkg::STATUS_W-1:0]      status,
  output logic [krwlt_pkg::HANDLE_W-1:0]      grant_handle,
  output logic                                held_flag
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_FETCH = 4'b0100,
    S_EXEC  = 4'b1000
  } state_t;

  state_t state;

  // Captured request.
  krwlt_pkg::opcode_t                  op;
  logic [krwlt_pkg::KEY_BITS-1:0]      key;
  logic [krwlt_pkg::ID_BITS-1:0]       id;
  logic [krwlt_pkg::HANDLE_W-1:0]      handle;

  // Search bookkeeping.
  logic [krwlt_pkg::IDX_BITS:0]        cnt;
  logic                                pend;
  krwlt_pkg::idx_t                     pend_idx;
  logic                                found;
  krwlt_pkg::idx_t                     hit_idx;
  logic                                free_found;
  krwlt_pkg::idx_t                     free_idx;
  krwlt_pkg::entry_t                   cur;

  logic [krwlt_pkg::ENTRIES-1:0]       valid;

  logic                                accept;
  logic                                commit;
  logic                                cnt_live;
  logic                                hit;
  krwlt_pkg::idx_t                     handle_idx;
  krwlt_pkg::idx_t                     raddr;
  logic [krwlt_pkg::ENTRY_BITS-1:0]    rdata;
  krwlt_pkg::entry_t                   rd_entry;
  krwlt_pkg::lookup_t                  look;
  krwlt_pkg::decision_t                dec;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign commit    = (state == S_EXEC) && !(rsp_valid && rsp_stall);
  assign cnt_live  = cnt < (krwlt_pkg::IDX_BITS + 1)'(krwlt_pkg::ENTRIES);

  // The release handle addresses the RAM in the accept cycle.
  assign handle_idx = (state == S_IDLE) ? krwlt_pkg::IDX_BITS'(release_handle)
                                        : krwlt_pkg::IDX_BITS'(handle);
  assign raddr      = (state == S_IDLE) ? handle_idx
                                        : cnt[krwlt_pkg::IDX_BITS-1:0];
  assign rd_entry   = rdata;

  // A returning entry hits on its key, and for a query also on its owner.
  assign hit = pend && valid[pend_idx] && (rd_entry.key == key) &&
               (op != krwlt_pkg::OP_QUERY || rd_entry.owner == id);

  krwlt_ram #(
    .WIDTH (krwlt_pkg::ENTRY_BITS),
    .DEPTH (krwlt_pkg::ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (commit && dec.we),
    .waddr (dec.widx),
    .wdata (dec.wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Search result handed to the rule logic.
  always_comb begin
    look            = '0;
    look.found      = found;
    look.hit_idx    = hit_idx;
    look.free_found = free_found;
    look.free_idx   = free_idx;
    look.handle_ok  = (32'(handle) < 32'(krwlt_pkg::ENTRIES)) && valid[handle_idx];
  end

  krwlt_decide u_decide (
    .op   (op),
    .key  (key),
    .id   (id),
    .look (look),
    .cur  (cur),
    .dec  (dec)
  );

  // Sequencer: accept, scan or fetch, then write back and respond.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      rsp_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      // A commit raises the response word; otherwise it drops once taken.
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (krwlt_pkg::opcode_t'(opcode) == krwlt_pkg::OP_RELEASE) ?
                     S_FETCH : S_SCAN;
          end
          pend <= 1'b0;
        end
        S_SCAN: begin
          pend <= cnt_live;
          if (hit || (!pend && !cnt_live)) begin
            state <= S_EXEC;
          end
        end
        S_FETCH: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (commit) begin
            state <= S_IDLE;
            if (dec.we) begin
              valid[dec.widx] <= dec.valid_val;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request capture, search datapath and response registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= krwlt_pkg::opcode_t'(opcode);
      key        <= krwlt_pkg::KEY_BITS'(lock_key);
      id         <= krwlt_pkg::ID_BITS'(requester_id);
      handle     <= release_handle;
      cnt        <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
      hit_idx    <= '0;
      free_idx   <= '0;
    end
    if (state == S_SCAN) begin
      pend_idx <= cnt[krwlt_pkg::IDX_BITS-1:0];
      if (cnt_live) begin
        cnt <= cnt + (krwlt_pkg::IDX_BITS + 1)'(1);
      end
      if (hit) begin
        found   <= 1'b1;
        hit_idx <= pend_idx;
        cur     <= rd_entry;
      end else if (pend && !valid[pend_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= pend_idx;
      end
    end
    if (state == S_FETCH) begin
      cur     <= rd_entry;
      hit_idx <= handle_idx;
    end
    if (commit) begin
      status       <= dec.status;
      grant_handle <= dec.grant;
      held_flag    <= dec.held;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/krwlt_ram.sv =====
// ----------------------------------------------------------------------------
// krwlt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module krwlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/krwlt_decide.sv =====
// ----------------------------------------------------------------------------
// krwlt_decide
// Grant, refusal and release rules applied to the entry found for a request.
// ----------------------------------------------------------------------------
`default_nettype none

module krwlt_decide (
  input  wire krwlt_pkg::opcode_t                    op,
  input  wire logic [krwlt_pkg::KEY_BITS-1:0]        key,
  input  wire logic [krwlt_pkg::ID_BITS-1:0]         id,
  input  wire krwlt_pkg::lookup_t                    look,
  input  wire krwlt_pkg::entry_t                     cur,
  output krwlt_pkg::decision_t                       dec
);

  krwlt_pkg::idx_t   lock_idx;
  krwlt_pkg::count_t rd_base;
  krwlt_pkg::count_t wr_base;
  logic [krwlt_pkg::ID_BITS-1:0] own_base;
  krwlt_pkg::count_t rd_dec;
  krwlt_pkg::count_t wr_dec;

  // A fresh entry starts with no holders.
  assign lock_idx = look.found ? look.hit_idx : look.free_idx;
  assign rd_base  = look.found ? cur.rd : '0;
  assign wr_base  = look.found ? cur.wr : '0;
  assign own_base = look.found ? cur.owner : '0;
  assign rd_dec   = cur.rd - krwlt_pkg::COUNT_BITS'(1);
  assign wr_dec   = cur.wr - krwlt_pkg::COUNT_BITS'(1);

  always_comb begin
    dec           = '0;
    dec.status    = krwlt_pkg::ST_DONE;
    dec.widx      = look.hit_idx;
    dec.wdata     = cur;
    case (op)
      krwlt_pkg::OP_SHARED, krwlt_pkg::OP_EXCL: begin
        dec.widx        = lock_idx;
        dec.wdata.key   = key;
        dec.wdata.rd    = rd_base;
        dec.wdata.wr    = wr_base;
        dec.wdata.owner = id;
        if (!look.found && !look.free_found) begin
          dec.status = krwlt_pkg::ST_FULL;
        end else if (op == krwlt_pkg::OP_EXCL) begin
          // Readers block a writer, and so does a writer with another id.
          if (rd_base != '0 || (wr_base != '0 && own_base != id)) begin
            dec.status = krwlt_pkg::ST_BUSY;
          end else if (wr_base == krwlt_pkg::COUNT_MAX) begin
            dec.status = krwlt_pkg::ST_LIMIT;
          end else begin
            dec.wdata.wr = wr_base + krwlt_pkg::COUNT_BITS'(1);
          end
        end else begin
          if (wr_base != '0) begin
            dec.status = krwlt_pkg::ST_BUSY;
          end else if (rd_base == krwlt_pkg::COUNT_MAX) begin
            dec.status = krwlt_pkg::ST_LIMIT;
          end else begin
            dec.wdata.rd = rd_base + krwlt_pkg::COUNT_BITS'(1);
          end
        end
        if (dec.status == krwlt_pkg::ST_DONE) begin
          dec.we        = 1'b1;
          dec.valid_val = 1'b1;
          dec.grant     = krwlt_pkg::HANDLE_W'(lock_idx);
        end
      end
      krwlt_pkg::OP_RELEASE: begin
        if (!look.handle_ok) begin
          dec.status = krwlt_pkg::ST_BADREL;
        end else if (cur.wr != '0) begin
          // Only the owning writer may drop a write hold.
          if (cur.owner != id) begin
            dec.status = krwlt_pkg::ST_BADREL;
          end else begin
            dec.wdata.wr = wr_dec;
            if (wr_dec == '0) begin
              dec.wdata.owner = '0;
            end
          end
        end else if (cur.rd != '0) begin
          dec.wdata.rd = rd_dec;
          if (rd_dec == '0) begin
            dec.wdata.owner = '0;
          end
        end else begin
          dec.status = krwlt_pkg::ST_BADREL;
        end
        if (dec.status == krwlt_pkg::ST_DONE) begin
          dec.we        = 1'b1;
          dec.valid_val = (dec.wdata.rd != '0) || (dec.wdata.wr != '0);
        end
      end
      krwlt_pkg::OP_QUERY: begin
        dec.held = look.found;
      end
      default: begin
        dec.status = krwlt_pkg::ST_DONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/krwlt_checker.sv =====
// ----------------------------------------------------------------------------
// krwlt_checker
// Port-level checks of the lock table responses, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyed_reader_writer_lock_table_assert.svh"

module krwlt_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           req_valid,
  input wire logic                           req_stall,
  input wire logic                           rsp_valid,
  input wire logic                           rsp_stall,
  input wire logic [krwlt_pkg::STATUS_W-1:0] status,
  input wire logic [krwlt_pkg::HANDLE_W-1:0] grant_handle,
  input wire logic                           held_flag
);

  // No response word is left over from before reset.
  `KRWLT_ASSERT_ALWAYS(a_rst_clears, rst |=> !rsp_valid, "response valid after reset")

  // A stalled response word stays put.
  `KRWLT_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(status), "response changed while stalled")

  // Only done answers carry a query hit.
  `KRWLT_ASSERT(a_held_done, rsp_valid && held_flag |-> status == krwlt_pkg::ST_DONE, "held flag with failing status")

  // A nonzero handle is only granted with done.
  `KRWLT_ASSERT(a_grant_done, rsp_valid && grant_handle != '0 |-> status == krwlt_pkg::ST_DONE, "grant handle with failing status")

  // A new request is not taken in the cycle right after one was accepted.
  `KRWLT_ASSERT(a_one_at_a_time, req_valid && !req_stall |=> req_stall, "request accepted twice in a row")

endmodule

bind keyed_reader_writer_lock_table krwlt_checker u_krwlt_checker (.*);

`default_nettype wire
